/* hw/rtl/brm_pkg.sv */
// ----------------------------------------------------------------------------
// brm_pkg
// Shared widths, controller states and the command and status bundles of the
// radix-2 Booth multiplier.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int WIDTH = 16;
  localparam int PROD_W = 2 * WIDTH;
  localparam int ACC_W = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } brm_state_t;

  typedef enum logic [1:0] {
    BOOTH_HOLD_LO = 2'b00,
    BOOTH_ADD     = 2'b01,
    BOOTH_SUB     = 2'b10,
    BOOTH_HOLD_HI = 2'b11
  } booth_op_t;

  typedef struct packed {
    logic load;
    logic step;
    logic latch;
  } brm_cmd_t;

  typedef struct packed {
    logic last;
  } brm_sts_t;

endpackage

/* hw/rtl/brm_dp.sv */
// ----------------------------------------------------------------------------
// brm_dp
// Booth datapath: accumulator, multiplier shift register, extra low bit, step
// counter and the output product register.
// ----------------------------------------------------------------------------
module brm_dp
  import brm_pkg::*;
(
  input  logic              clk,
  input  logic [WIDTH-1:0]  multiplicand,
  input  logic [WIDTH-1:0]  multiplier,
  input  brm_cmd_t          cmd,
  output brm_sts_t          sts,
  output logic [PROD_W-1:0] product
);

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [WIDTH-1:0]  q_r, q_nxt;
  logic              qm1_r, qm1_nxt;
  logic [WIDTH-1:0]  mcand_r, mcand_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ACC_W-1:0]  m_ext;
  logic [ACC_W-1:0]  sum;
  booth_op_t         op;

  always_comb begin
    m_ext = {mcand_r[WIDTH-1], mcand_r};
    op = booth_op_t'({q_r[0], qm1_r});
    case (op)
      BOOTH_SUB: sum = acc_r - m_ext;
      BOOTH_ADD: sum = acc_r + m_ext;
      default:   sum = acc_r;
    endcase
  end

  always_comb begin
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    qm1_nxt   = qm1_r;
    mcand_nxt = mcand_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    if (cmd.load) begin
      acc_nxt   = '0;
      q_nxt     = multiplier;
      qm1_nxt   = 1'b0;
      mcand_nxt = multiplicand;
      cnt_nxt   = CNT_W'(WIDTH);
    end else if (cmd.step) begin
      acc_nxt = {sum[ACC_W-1], sum[ACC_W-1:1]};
      q_nxt   = {sum[0], q_r[WIDTH-1:1]};
      qm1_nxt = q_r[0];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.latch) begin
      prod_nxt = {acc_r[WIDTH-1:0], q_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    qm1_r   <= qm1_nxt;
    mcand_r <= mcand_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
  end

  assign sts.last = (cnt_r == CNT_W'(1));
  assign product  = prod_r;

endmodule

/* hw/rtl/brm_ctrl.sv */
// ----------------------------------------------------------------------------
// brm_ctrl
// Controller: sequences load, Booth steps and hand-off of the product into
// the output register, and owns the result valid flag.
// ----------------------------------------------------------------------------
module brm_ctrl
  import brm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output brm_cmd_t cmd,
  input  brm_sts_t sts
);

  brm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (sts.last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = in_valid ? ST_RUN : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE) || (state_r == ST_DONE && out_free);
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state_r == ST_RUN);
    cmd.latch = (state_r == ST_DONE) && out_free;
    if (cmd.latch) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/booth_radix2_multiplier.sv */
// ----------------------------------------------------------------------------
// booth_radix2_multiplier
// Signed 16 x 16 radix-2 Booth sequential multiplier with a 32-bit product.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries a request of two signed
//   operands, in_multiplicand and in_multiplier. Result channel
//   (out_valid/out_ready) carries the signed product out_product.
//   The accept cycle loads the operands, then one add-or-subtract and
//   arithmetic shift step runs per multiplier bit (16 steps) through a single
//   17-bit adder, then the product moves into the output register.
//   A new request is not taken while a product is in progress; the next
//   request is taken in the same cycle the finished product moves to the
//   output register.
//   A product waiting in the output register does not block a new request;
//   if the receiver stalls, the next finished product holds in the datapath
//   and the input channel stays not ready until the output register frees.
//   Synchronous reset (rst_n low) returns the controller to idle and drops
//   any pending result.
// ----------------------------------------------------------------------------
module booth_radix2_multiplier
  import brm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WIDTH-1:0]  in_multiplicand,
  input  logic signed [WIDTH-1:0]  in_multiplier,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [PROD_W-1:0] out_product
);

  brm_cmd_t          cmd;
  brm_sts_t          sts;
  logic [PROD_W-1:0] product;

  brm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  brm_dp u_dp (
    .clk          (clk),
    .multiplicand (in_multiplicand),
    .multiplier   (in_multiplier),
    .cmd          (cmd),
    .sts          (sts),
    .product      (product)
  );

  assign out_product = product;

endmodule

/* hw/rtl/brm_chk.sv */
// ----------------------------------------------------------------------------
// brm_chk
// Port-level checks of the Booth multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module brm_chk
  import brm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic signed [WIDTH-1:0]  in_multiplicand,
  input logic signed [WIDTH-1:0]  in_multiplier,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [PROD_W-1:0] out_product
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=>
      in_valid && $stable(in_multiplicand) && $stable(in_multiplier))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_product))
    else $error("product changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a product is in progress");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind booth_radix2_multiplier brm_chk u_brm_chk (.*);

/* bench/tb_booth_radix2_multiplier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_booth_radix2_multiplier
// Drives signed operand requests into the Booth multiplier and checks every
// product in order against a bit-level Booth recoding predictor, across
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_booth_radix2_multiplier;
  import brm_pkg::*;

  class product_board;
    logic [PROD_W-1:0] pending_products[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function logic [PROD_W-1:0] booth_product(logic [WIDTH-1:0] mcand,
                                              logic [WIDTH-1:0] mplier);
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] mcand_ext;
      logic [WIDTH-1:0] shift_q;
      logic q_prev;
      booth_op_t op;
      acc = '0;
      shift_q = mplier;
      q_prev = 1'b0;
      mcand_ext = {mcand[WIDTH-1], mcand};
      for (int i = 0; i < WIDTH; i++) begin
        op = booth_op_t'({shift_q[0], q_prev});
        case (op)
          BOOTH_SUB: acc = acc - mcand_ext;
          BOOTH_ADD: acc = acc + mcand_ext;
          default: ;
        endcase
        q_prev = shift_q[0];
        shift_q = {acc[0], shift_q[WIDTH-1:1]};
        acc = {acc[ACC_W-1], acc[ACC_W-1:1]};
      end
      return {acc[WIDTH-1:0], shift_q};
    endfunction

    function void note_request(logic [WIDTH-1:0] mcand, logic [WIDTH-1:0] mplier);
      pending_products.push_back(booth_product(mcand, mplier));
    endfunction

    function void check_product(logic [PROD_W-1:0] actual);
      logic [PROD_W-1:0] want;
      if (pending_products.size() == 0) begin
        errors++;
        $display("%0t: unexpected product, expected none, actual %0d",
                 $time, $signed(actual));
      end else begin
        want = pending_products.pop_front();
        if (want !== actual) begin
          errors++;
          $display("%0t: product mismatch, expected %0d, actual %0d",
                   $time, $signed(want), $signed(actual));
        end
      end
    endfunction

    function int count();
      return pending_products.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WIDTH-1:0] in_multiplicand = '0;
  logic signed [WIDTH-1:0] in_multiplier = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PROD_W-1:0] out_product;

  logic in_take = 1'b0;
  logic out_take = 1'b0;
  logic [WIDTH-1:0] mcand_s;
  logic [WIDTH-1:0] mplier_s;
  logic [PROD_W-1:0] product_s;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  product_board board = new();

  booth_radix2_multiplier i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_multiplicand(in_multiplicand),
    .in_multiplier  (in_multiplier),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_product    (out_product)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample handshakes mid-cycle, where everything has settled
  always @(negedge clk) begin
    in_take = in_valid && in_ready;
    out_take = out_valid && out_ready;
    mcand_s = in_multiplicand;
    mplier_s = in_multiplier;
    product_s = out_product;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_take) board.note_request(mcand_s, mplier_s);
      if (out_take) board.check_product(product_s);
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_take || out_take) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function logic [WIDTH-1:0] pick_operand();
    logic [WIDTH-1:0] val;
    case ($urandom_range(0, 9))
      0: val = {1'b1, {(WIDTH-1){1'b0}}};
      1: val = {1'b0, {(WIDTH-1){1'b1}}};
      2: val = '1;
      3: val = WIDTH'($urandom_range(0, 2));
      default: val = WIDTH'($urandom);
    endcase
    return val;
  endfunction

  task send_request(input logic [WIDTH-1:0] mcand, input logic [WIDTH-1:0] mplier);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_multiplicand <= mcand;
    in_multiplier <= mplier;
    @(posedge clk);
    while (!in_take) @(posedge clk);
  endtask

  task hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.count() != 0) @(posedge clk);
  endtask

  task run_phase(input int n_items, input int sender_idle, input int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (n_items) send_request(pick_operand(), pick_operand());
  endtask

  logic [WIDTH-1:0] dir_a[19];
  logic [WIDTH-1:0] dir_b[19];

  initial begin
    dir_a = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
              16'h8000, 16'h0001, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h5555,
              16'hAAAA, 16'h5555, 16'hFFFF, 16'h3039, 16'h8000};
    dir_b = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
              16'h0001, 16'h8000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000, 16'h5555,
              16'hAAAA, 16'hAAAA, 16'h0001, 16'hE57B, 16'h5555};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 0;
    stall_pct = 30;
    foreach (dir_a[i]) send_request(dir_a[i], dir_b[i]);
    hold_until_drained();

    run_phase(140, 0, 0);
    run_phase(140, 74, 0);
    hold_until_drained();
    run_phase(140, 0, 74);
    run_phase(130, 9, 9);

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.count() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (board.errors == 0 && board.count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/brm_pkg.sv
hw/rtl/brm_dp.sv
hw/rtl/brm_ctrl.sv
hw/rtl/booth_radix2_multiplier.sv
hw/rtl/brm_chk.sv
bench/tb_booth_radix2_multiplier.sv
